[src/tmre_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmre_pkg: shared types and constants of the mouse report encoder
// Word formats, the report format codes, the queue entry and the sequencer
// phases, with a few small helpers for the decimal fields.
// ----------------------------------------------------------------------------
package tmre_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACKING = 1'b0,
    CFG_FORMAT   = 1'b1
  } cfg_idx_t;

  // report format codes, unused code falls back to x10
  typedef enum logic [1:0] {
    FMT_X10   = 2'd0,
    FMT_SGR   = 2'd1,
    FMT_URXVT = 2'd2
  } fmt_t;

  // input word: one mouse event
  typedef struct packed {
    logic [11:0] row;
    logic [11:0] column;
    logic [2:0]  button;
    logic [2:0]  modifier_bits;
    logic        is_press;
    logic        is_motion;
  } in_word_t;

  // output word: one report byte
  typedef struct packed {
    logic [7:0] report_byte;
    logic       last_byte;
  } out_word_t;

  // classified event, as held in the queue
  typedef struct packed {
    fmt_t        fmt;
    logic        press;
    logic [6:0]  code;
    logic [1:0]  code_len;   // digit count minus one
    logic [12:0] col1;       // one-based column
    logic [1:0]  col_len;
    logic [12:0] row1;       // one-based row
    logic [1:0]  row_len;
  } job_t;

  // queue depth, a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_BRACKET,
    PH_LT,
    PH_X_M,
    PH_X_CODE,
    PH_X_COL,
    PH_X_ROW,
    PH_CODE,
    PH_SEP1,
    PH_COL,
    PH_SEP2,
    PH_ROW,
    PH_FINAL
  } phase_t;

  // report bytes
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LBRK  = 8'h5B;
  localparam logic [7:0] BYTE_LT    = 8'h3C;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_UPM   = 8'h4D;
  localparam logic [7:0] BYTE_LOWM  = 8'h6D;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] X10_BIAS   = 8'h20;
  localparam logic [7:0] X10_MAX    = 8'd255;

  // number of decimal digits minus one
  function automatic logic [1:0] dec_len(input logic [12:0] v);
    logic [1:0] n;
    if (v >= 13'd1000) n = 2'd3;
    else if (v >= 13'd100) n = 2'd2;
    else if (v >= 13'd10) n = 2'd1;
    else n = 2'd0;
    return n;
  endfunction

  // weight of a decimal place
  function automatic logic [12:0] dec_place(input logic [1:0] pl);
    logic [12:0] w;
    case (pl)
      2'd0:    w = 13'd1;
      2'd1:    w = 13'd10;
      2'd2:    w = 13'd100;
      default: w = 13'd1000;
    endcase
    return w;
  endfunction

  // x10 coordinate byte from a one-based coordinate, saturated
  function automatic logic [7:0] x10_coord(input logic [12:0] v1);
    logic [13:0] s;
    s = {1'b0, v1} + 14'd32;
    return (s > 14'(X10_MAX)) ? X10_MAX : s[7:0];
  endfunction

endpackage
`default_nettype wire

[src/tmre_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmre_front: event intake and classification
// Holds the configuration registers, forms the button code, clamps and
// biases the coordinates and sizes the decimal fields of each event.
// ----------------------------------------------------------------------------
module tmre_front #(
  parameter int unsigned MAX_COORD = 4095
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  tmre_pkg::in_word_t                 in_word,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [tmre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [tmre_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               q_push,
  output tmre_pkg::job_t                     q_data,
  input  wire                                q_full
);
  import tmre_pkg::*;

  logic        track_r, track_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  fmt_t        fmt;
  logic [11:0] row_c, col_c;
  logic [6:0]  code;
  logic [12:0] code_w;

  // configuration writes, always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    track_nxt = track_r;
    fmt_nxt   = fmt_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRACKING: track_nxt = cfg_wdata[0];
        CFG_FORMAT:   fmt_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= 1'b0;
      fmt_r   <= 2'd0;
    end else begin
      track_r <= track_nxt;
      fmt_r   <= fmt_nxt;
    end
  end

  // format decode
  always_comb begin
    unique case (fmt_t'(fmt_r))
      FMT_SGR:   fmt = FMT_SGR;
      FMT_URXVT: fmt = FMT_URXVT;
      default:   fmt = FMT_X10;
    endcase
  end

  // coordinate clamp
  assign row_c = ({20'd0, in_word.row} > 32'(MAX_COORD)) ? 12'(MAX_COORD) : in_word.row;
  assign col_c = ({20'd0, in_word.column} > 32'(MAX_COORD)) ? 12'(MAX_COORD) : in_word.column;

  // button code
  always_comb begin
    unique case (in_word.button)
      3'd0, 3'd1, 3'd2: code = {4'd0, in_word.button};
      3'd4:             code = 7'd64;
      3'd5:             code = 7'd65;
      default:          code = 7'd3;
    endcase
    if (in_word.is_motion) code = code + 7'd32;
    if (!in_word.is_press && !in_word.is_motion && fmt == FMT_X10) code = 7'd3;
    code = code + {2'd0, in_word.modifier_bits, 2'd0};
  end

  assign code_w = {6'd0, code};

  // queue entry
  always_comb begin
    q_data.fmt      = fmt;
    q_data.press    = in_word.is_press;
    q_data.code     = code;
    q_data.code_len = dec_len(code_w);
    q_data.col1     = {1'b0, col_c} + 13'd1;
    q_data.col_len  = dec_len({1'b0, col_c} + 13'd1);
    q_data.row1     = {1'b0, row_c} + 13'd1;
    q_data.row_len  = dec_len({1'b0, row_c} + 13'd1);
  end

  // intake, events are dropped while tracking is off
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && track_r;

endmodule
`default_nettype wire

[src/tmre_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmre_queue: short event queue
// Two-entry fifo between intake and the byte sequencer.
// ----------------------------------------------------------------------------
module tmre_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  tmre_pkg::job_t  push_data,
  output logic            full,
  input  wire             pop,
  output tmre_pkg::job_t  head,
  output logic            head_valid
);
  import tmre_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

[src/tmre_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmre_back: report byte sequencer
// Walks the report of the event at the queue head, one byte per cycle while
// not stalled, decimal fields one digit per byte, into the output register.
// ----------------------------------------------------------------------------
module tmre_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  tmre_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output tmre_pkg::out_word_t out_word
);
  import tmre_pkg::*;

  phase_t      state_r, state_nxt;
  job_t        cur_r;
  logic [12:0] num_r, num_nxt;
  logic [1:0]  pl_r, pl_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r;
  logic        adv, emit;
  logic [7:0]  byte_sel;
  logic        last_sel;
  logic [12:0] place, sub;
  logic [3:0]  digit;

  // output register free or being drained
  assign adv = !out_valid_r || !out_stall;

  // next phase
  always_comb begin
    state_nxt = state_r;
    if (adv) begin
      unique case (state_r)
        PH_IDLE:    if (q_valid) state_nxt = PH_BRACKET;
        PH_BRACKET: begin
          unique case (cur_r.fmt)
            FMT_SGR:   state_nxt = PH_LT;
            FMT_URXVT: state_nxt = PH_CODE;
            default:   state_nxt = PH_X_M;
          endcase
        end
        PH_LT:      state_nxt = PH_CODE;
        PH_X_M:     state_nxt = PH_X_CODE;
        PH_X_CODE:  state_nxt = PH_X_COL;
        PH_X_COL:   state_nxt = PH_X_ROW;
        PH_X_ROW:   state_nxt = PH_IDLE;
        PH_CODE:    if (pl_r == 2'd0) state_nxt = PH_SEP1;
        PH_SEP1:    state_nxt = PH_COL;
        PH_COL:     if (pl_r == 2'd0) state_nxt = PH_SEP2;
        PH_SEP2:    state_nxt = PH_ROW;
        PH_ROW:     if (pl_r == 2'd0) state_nxt = PH_FINAL;
        PH_FINAL:   state_nxt = PH_IDLE;
        default:    state_nxt = PH_IDLE;
      endcase
    end
  end

  // current decimal digit, by parallel threshold compares
  assign place = dec_place(pl_r);

  always_comb begin
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, num_r} >= 14'(k) * {1'b0, place}) digit = 4'(k);
    end
  end

  assign sub = 13'(digit) * place;

  // byte selection and digit engine
  always_comb begin
    byte_sel = BYTE_ESC;
    last_sel = 1'b0;
    num_nxt  = num_r;
    pl_nxt   = pl_r;
    unique case (state_r)
      PH_IDLE:    byte_sel = BYTE_ESC;
      PH_BRACKET: begin
        byte_sel = BYTE_LBRK;
        num_nxt  = {6'd0, cur_r.code};
        pl_nxt   = cur_r.code_len;
      end
      PH_LT:      byte_sel = BYTE_LT;
      PH_X_M:     byte_sel = BYTE_UPM;
      PH_X_CODE:  byte_sel = {1'b0, cur_r.code} + X10_BIAS;
      PH_X_COL:   byte_sel = x10_coord(cur_r.col1);
      PH_X_ROW: begin
        byte_sel = x10_coord(cur_r.row1);
        last_sel = 1'b1;
      end
      PH_CODE, PH_COL, PH_ROW: begin
        byte_sel = BYTE_ZERO + {4'd0, digit};
        num_nxt  = num_r - sub;
        pl_nxt   = pl_r - 2'd1;
      end
      PH_SEP1: begin
        byte_sel = BYTE_SEMI;
        num_nxt  = cur_r.col1;
        pl_nxt   = cur_r.col_len;
      end
      PH_SEP2: begin
        byte_sel = BYTE_SEMI;
        num_nxt  = cur_r.row1;
        pl_nxt   = cur_r.row_len;
      end
      PH_FINAL: begin
        byte_sel = (cur_r.fmt == FMT_SGR && !cur_r.press) ? BYTE_LOWM : BYTE_UPM;
        last_sel = 1'b1;
      end
      default: ;
    endcase
  end

  // handshake outputs of the sequencer
  assign emit          = adv && (state_r != PH_IDLE || q_valid);
  assign q_pop         = adv && state_r == PH_IDLE && q_valid;
  assign out_valid_nxt = adv ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (adv) begin
      num_r <= num_nxt;
      pl_r  <= pl_nxt;
    end
    if (emit) begin
      out_word_r.report_byte <= byte_sel;
      out_word_r.last_byte   <= last_sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_sel) |=> (state_r == PH_IDLE))
    else $error("sequencer did not return to idle after final byte");

  a_digit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && pl_r != 2'd0 && (state_r == PH_CODE || state_r == PH_COL || state_r == PH_ROW))
      |=> (state_r == $past(state_r)))
    else $error("decimal field ended early");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted byte lost");
`endif

endmodule
`default_nettype wire

[src/terminal_mouse_report_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_mouse_report_encoder: mouse event to terminal report bytes
// Top level: intake and classification, a two-entry event queue and the
// byte sequencer that writes the escape sequence.
// ----------------------------------------------------------------------------
// Each accepted mouse event yields its report as a run of bytes, one word per
// cycle on the output while out_stall is low, with last_byte set on the final
// one: 6 bytes in x10 format, 8 to 16 in urxvt and 9 to 17 in sgr. When the
// next event is queued, its first byte follows the final byte of the previous
// one with no gap. Events are taken while the two-entry queue in front of the
// sequencer has room, and events seen while tracking is off are dropped
// without output. Configuration writes are always ready; write them only
// while no report is pending. No clearing pass follows reset.
module terminal_mouse_report_encoder #(
  parameter int unsigned MAX_COORD = 4095
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  tmre_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  wire                                out_stall,
  output tmre_pkg::out_word_t                out_word,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [tmre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [tmre_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tmre_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  job_t q_data, q_head;

  // intake and classification
  tmre_front #(
    .MAX_COORD (MAX_COORD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  // event queue
  tmre_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  // byte sequencer
  tmre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

[dv/terminal_mouse_report_encoder_checker.sv]
// ----------------------------------------------------------------------------
// terminal_mouse_report_encoder_checker: report predictor and byte checker
// Follows the configuration writes and the accepted mouse events, works out
// the escape sequence each event should produce and compares every accepted
// output word, byte and last flag, against the oldest expected one.
// ----------------------------------------------------------------------------
module terminal_mouse_report_encoder_checker #(
  parameter int unsigned MAX_COORD = 4095
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  tmre_pkg::in_word_t                in_word,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  tmre_pkg::out_word_t               out_word,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [tmre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmre_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  import tmre_pkg::*;

  // button field values and the codes they map to
  localparam logic [2:0]  BTN_NONE        = 3'd3;
  localparam logic [2:0]  BTN_WHEEL_UP    = 3'd4;
  localparam logic [2:0]  BTN_WHEEL_DOWN  = 3'd5;
  localparam int unsigned CODE_NONE       = 3;
  localparam int unsigned CODE_WHEEL_UP   = 64;
  localparam int unsigned CODE_WHEEL_DOWN = 65;
  localparam int unsigned MOTION_BIAS     = 32;
  localparam int unsigned SHIFT_BIAS      = 4;
  localparam int unsigned CTRL_BIAS       = 8;
  localparam int unsigned ALT_BIAS        = 16;
  localparam int unsigned X10_COORD_BIAS  = 33;
  localparam int unsigned DEC_LIMIT       = 9999;

  // shadow copy of the configuration
  logic       tracking_on;
  logic [1:0] report_fmt;

  // report bytes still owed by the block, oldest first
  out_word_t  expected_bytes[$];
  int         errors = 0;

  assign fail_count = errors;

  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors = errors + 1;
  endtask

  function automatic int unsigned clamp_coord(input logic [11:0] v);
    return (v > MAX_COORD) ? MAX_COORD : int'(v);
  endfunction

  // one-based decimal coordinate, held to four digits
  function automatic int unsigned one_based(input int unsigned v);
    return (v + 1 > DEC_LIMIT) ? DEC_LIMIT : v + 1;
  endfunction

  function automatic logic [7:0] x10_byte(input int unsigned v);
    return (v + X10_COORD_BIAS > 255) ? 8'd255 : 8'(v + X10_COORD_BIAS);
  endfunction

  // queue up the escape sequence that one event should produce
  function automatic void predict_report(input in_word_t ev);
    logic [7:0]  seq[$];
    int unsigned row_c;
    int unsigned col_c;
    int unsigned code;
    logic        decimal;
    logic        sgr;
    string       text;
    out_word_t   w;
    row_c   = clamp_coord(ev.row);
    col_c   = clamp_coord(ev.column);
    sgr     = (report_fmt == FMT_SGR);
    decimal = sgr || (report_fmt == FMT_URXVT);
    if (!tracking_on) return;

    // button code, then motion, x10 release and modifiers
    if (ev.button <= BTN_NONE) code = ev.button;
    else if (ev.button == BTN_WHEEL_UP) code = CODE_WHEEL_UP;
    else if (ev.button == BTN_WHEEL_DOWN) code = CODE_WHEEL_DOWN;
    else code = CODE_NONE;
    if (ev.is_motion) code += MOTION_BIAS;
    if (!ev.is_press && !ev.is_motion && !decimal) code = CODE_NONE;
    if (ev.modifier_bits[0]) code += SHIFT_BIAS;
    if (ev.modifier_bits[1]) code += CTRL_BIAS;
    if (ev.modifier_bits[2]) code += ALT_BIAS;

    seq.push_back(BYTE_ESC);
    seq.push_back(BYTE_LBRK);
    if (decimal) begin
      if (sgr) seq.push_back(BYTE_LT);
      text = $sformatf("%0d;%0d;%0d", code, one_based(col_c), one_based(row_c));
      for (int i = 0; i < text.len(); i++) seq.push_back(text.getc(i));
      seq.push_back((sgr && !ev.is_press) ? BYTE_LOWM : BYTE_UPM);
    end else begin
      seq.push_back(BYTE_UPM);
      seq.push_back(8'(code) + X10_BIAS);
      seq.push_back(x10_byte(col_c));
      seq.push_back(x10_byte(row_c));
    end

    foreach (seq[i]) begin
      w.report_byte = seq[i];
      w.last_byte   = (i == seq.size() - 1);
      expected_bytes.push_back(w);
    end
  endfunction

  // follow config writes and events, check each accepted output word
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      tracking_on = 1'b0;
      report_fmt  = FMT_X10;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TRACKING) tracking_on = cfg_wdata[0];
        else if (cfg_index == CFG_FORMAT) report_fmt = cfg_wdata;
      end
      if (in_valid && !in_stall) predict_report(in_word);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected word byte=%02h last=%0b",
                               out_word.report_byte, out_word.last_byte));
        end else begin
          exp_w = expected_bytes.pop_front();
          if (out_word.report_byte !== exp_w.report_byte)
            flag_error($sformatf("report_byte %02h, expected %02h",
                                 out_word.report_byte, exp_w.report_byte));
          if (out_word.last_byte !== exp_w.last_byte)
            flag_error($sformatf("last_byte %0b, expected %0b (byte %02h)",
                                 out_word.last_byte, exp_w.last_byte,
                                 exp_w.report_byte));
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

[dv/terminal_mouse_report_encoder_test.sv]
// ----------------------------------------------------------------------------
// terminal_mouse_report_encoder_test: testbench top of the mouse encoder
// Drives directed and random mouse events under every report format and
// with tracking on and off, with random bursts of sender gaps and receiver
// stalls; the checker beside the block predicts and compares the reports.
// ----------------------------------------------------------------------------
module terminal_mouse_report_encoder_test;
  import tmre_pkg::*;

  localparam logic [1:0] FMT_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         SETTLE_WAIT  = 40;
  localparam int         RANDOM_ROUNDS = 8;
  localparam int         ROUND_EVENTS  = 18;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_stall;
  in_word_t  in_word    = '0;
  logic      out_valid;
  logic      out_stall  = 1'b0;
  out_word_t out_word;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   stall_left  = 0;
  logic quiet_run   = 1'b0;

  terminal_mouse_report_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  terminal_mouse_report_encoder_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("terminal_mouse_report_encoder_test: FAIL");
      $finish;
    end
  end

  // receiver stalls in random bursts, none in the quiet run
  always @(posedge clk) begin
    if (!rst_n || quiet_run) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 23);
    end
  end

  function automatic in_word_t mouse_word(input int row, input int col,
                                          input int btn, input int mods,
                                          input bit press, input bit motion);
    in_word_t w;
    w.row           = 12'(row);
    w.column        = 12'(col);
    w.button        = 3'(btn);
    w.modifier_bits = 3'(mods);
    w.is_press      = press;
    w.is_motion     = motion;
    return w;
  endfunction

  // coordinates biased toward the x10 clamp and decimal digit boundaries
  function automatic int rand_coord();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 15);
      1: v = $urandom_range(218, 230);
      2: begin
        case ($urandom_range(0, 7))
          0: v = 8;
          1: v = 9;
          2: v = 98;
          3: v = 99;
          4: v = 998;
          5: v = 999;
          6: v = 4094;
          default: v = 4095;
        endcase
      end
      default: v = $urandom_range(0, 4095);
    endcase
    return v;
  endfunction

  // one event word, with a random sender gap ahead of it
  task automatic send_mouse(input in_word_t w);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every expected byte is out, then let the block settle
  task automatic wait_reports_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // write both registers back to back
  task automatic set_mode(input logic track, input logic [1:0] fmt);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TRACKING;
    cfg_wdata <= {1'b0, track};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_FORMAT;
    cfg_wdata <= fmt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int       round;
    int       n;
    logic     track;
    logic [1:0] fmt;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tracking off after reset: no output
    send_mouse(mouse_word(0, 0, 0, 0, 1, 0));
    send_mouse(mouse_word(4095, 4095, 7, 7, 1, 1));
    wait_reports_done();

    // x10: clamps, every button, releases, hover, wheels
    set_mode(1'b1, FMT_X10);
    send_mouse(mouse_word(0, 0, 0, 0, 1, 0));
    send_mouse(mouse_word(4095, 4095, 2, 7, 1, 0));
    send_mouse(mouse_word(222, 223, 1, 0, 1, 0));
    send_mouse(mouse_word(5, 6, 0, 0, 0, 0));
    send_mouse(mouse_word(5, 6, 2, 2, 0, 1));
    send_mouse(mouse_word(1, 1, 3, 0, 0, 1));
    send_mouse(mouse_word(40, 50, 4, 1, 1, 0));
    send_mouse(mouse_word(60, 70, 5, 4, 1, 0));
    send_mouse(mouse_word(7, 8, 6, 0, 1, 0));
    send_mouse(mouse_word(9, 10, 7, 3, 1, 1));
    wait_reports_done();

    // sgr: lower-case m on release, digit boundaries, widest code
    set_mode(1'b1, FMT_SGR);
    send_mouse(mouse_word(10, 20, 0, 0, 0, 0));
    send_mouse(mouse_word(4095, 4095, 2, 7, 1, 0));
    send_mouse(mouse_word(300, 400, 5, 7, 1, 1));
    send_mouse(mouse_word(8, 9, 1, 0, 1, 0));
    send_mouse(mouse_word(98, 998, 7, 0, 0, 1));
    wait_reports_done();

    // urxvt
    set_mode(1'b1, FMT_URXVT);
    send_mouse(mouse_word(0, 0, 0, 0, 0, 0));
    send_mouse(mouse_word(99, 999, 4, 2, 1, 1));
    send_mouse(mouse_word(4095, 0, 6, 0, 0, 0));
    send_mouse(mouse_word(9, 4094, 2, 5, 1, 0));
    wait_reports_done();

    // unused format code falls back to x10
    set_mode(1'b1, FMT_UNUSED);
    send_mouse(mouse_word(3, 4, 0, 0, 0, 0));
    send_mouse(mouse_word(300, 300, 1, 6, 1, 0));
    wait_reports_done();

    // tracking switched off again
    set_mode(1'b0, FMT_SGR);
    send_mouse(mouse_word(12, 34, 1, 1, 1, 0));
    wait_reports_done();

    // random rounds, each under a random setting; the last one without idling
    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      track = ($urandom_range(0, 5) != 0) || (round == RANDOM_ROUNDS - 1);
      fmt   = 2'($urandom_range(0, 3));
      if (round == RANDOM_ROUNDS - 1) quiet_run <= 1'b1;
      set_mode(track, fmt);
      for (n = 0; n < ROUND_EVENTS; n++)
        send_mouse(mouse_word(rand_coord(), rand_coord(), $urandom_range(0, 7),
                              $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
      wait_reports_done();
    end

    if (fail_count == 0)
      $display("terminal_mouse_report_encoder_test: PASS");
    else
      $display("terminal_mouse_report_encoder_test: FAIL");
    $finish;
  end

endmodule
